FILE: rtl/tbfs_pkg.sv
`default_nettype none

package tbfs_pkg;

    // scan length and field widths
    localparam int MAX_ELEMENTS = 4096;
    localparam int POS_W        = $clog2(MAX_ELEMENTS);
    localparam int IDX_W        = 12;
    localparam int VAL_W        = 32;
    localparam int ITER_W       = 48;
    localparam int SIZE_W       = 13;
    localparam int DEN_W        = SIZE_W + 1;

    // stream payload widths
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 48;

    // configuration port
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_MEAN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BEST_LOCAL_MEAN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ITERATION       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE        = 2'd3;

    // saturation bounds of a Q16.16 delta
    localparam logic [VAL_W-1:0] DELTA_MIN = 32'h8000_0000;
    localparam logic [VAL_W-1:0] DELTA_MAX = 32'h7fff_ffff;

    // queue between classifier and evaluator
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // bit-serial divider
    localparam int DIV_STEPS = VAL_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    typedef struct packed {
        logic signed [VAL_W-1:0] current_mean;
        logic signed [VAL_W-1:0] best_local_mean;
        logic [ITER_W-1:0]       iteration;
        logic [SIZE_W-1:0]       set_size;
    } tbfs_cfg_t;

    // one classified element, ready for division and selection
    typedef struct packed {
        logic              num_neg;
        logic [VAL_W-1:0]  num_mag;
        logic [DEN_W-1:0]  den;
        logic              usable;
        logic              tabu;
        logic              last;
    } tbfs_item_t;

endpackage

`default_nettype wire

FILE: rtl/tbfs_front.sv
`default_nettype none

module tbfs_front (
    input  var tbfs_pkg::tbfs_cfg_t           cfg,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire [tbfs_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire                               s_tuser,
    input  wire                               s_tlast,
    input  wire                               q_full,
    output logic                              q_push,
    output tbfs_pkg::tbfs_item_t              q_item
);
    import tbfs_pkg::*;

    logic signed [VAL_W-1:0] gain;
    logic [ITER_W-1:0]       expiry;
    logic signed [VAL_W:0]   gain_x;
    logic signed [VAL_W:0]   mean_x;
    logic signed [VAL_W:0]   diff;
    logic [VAL_W:0]          diff_neg;
    logic                    member;

    assign gain   = s_tdata[VAL_W-1:0];
    assign expiry = s_tdata[VAL_W+ITER_W-1:VAL_W];
    assign member = s_tuser;
    assign gain_x = {gain[VAL_W-1], gain};
    assign mean_x = {cfg.current_mean[VAL_W-1], cfg.current_mean};

    // numerator sign and magnitude; magnitude never exceeds 2^32-1
    assign diff     = member ? (mean_x - gain_x) : (gain_x - mean_x);
    assign diff_neg = -diff;

    always_comb begin
        q_item.num_neg = diff[VAL_W];
        q_item.num_mag = diff[VAL_W] ? diff_neg[VAL_W-1:0] : diff[VAL_W-1:0];
        q_item.den     = member ? ({1'b0, cfg.set_size} - DEN_W'(1))
                                : ({1'b0, cfg.set_size} + DEN_W'(1));
        // removal needs more than two members
        q_item.usable  = !member || (cfg.set_size > SIZE_W'(2));
        q_item.tabu    = expiry > cfg.iteration;
        q_item.last    = s_tlast;
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

endmodule

`default_nettype wire

FILE: rtl/tbfs_queue.sv
`default_nettype none

module tbfs_queue (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       push,
    input  var tbfs_pkg::tbfs_item_t  push_item,
    output logic                      full,
    input  wire                       pop,
    output tbfs_pkg::tbfs_item_t      pop_item,
    output logic                      valid
);
    import tbfs_pkg::*;

    tbfs_item_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        r = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
        return r;
    endfunction

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_item = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tbfs_back.sv
`default_nettype none

module tbfs_back (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  var tbfs_pkg::tbfs_cfg_t        cfg,
    input  wire                            q_valid,
    input  var tbfs_pkg::tbfs_item_t       q_item,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic [tbfs_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tuser
);
    import tbfs_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIX  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [DCNT_W-1:0]  cnt_reg, cnt_next;
    tbfs_item_t         item_reg;
    logic [VAL_W-1:0]   quo_reg, quo_next;
    logic [DEN_W-1:0]   rem_reg, rem_next;
    logic [VAL_W-1:0]   delta_reg;

    logic [POS_W-1:0]   position_reg, position_next;
    logic [VAL_W-1:0]   leader_delta_reg, leader_delta_next;
    logic [POS_W-1:0]   leader_index_reg, leader_index_next;
    logic               leader_valid_reg, leader_valid_next;

    logic               m_valid_reg, m_valid_next;
    logic               out_found_reg;
    logic [IDX_W-1:0]   out_index_reg;
    logic [VAL_W-1:0]   out_delta_reg;

    // divider step
    logic [DEN_W:0]     rem_sh;
    logic               rem_ge;
    logic [DEN_W:0]     rem_sub;

    // sign fix and saturation
    logic [VAL_W:0]     quo_x;
    logic [VAL_W:0]     quo_signed;
    logic [VAL_W-1:0]   delta_sat;

    // selection
    logic signed [VAL_W:0] aspire_sum;
    logic               admit;
    logic               take;
    logic               out_free;
    logic               done_go;
    logic               emit;
    logic               lead_valid_upd;
    logic [VAL_W-1:0]   lead_delta_upd;
    logic [POS_W-1:0]   lead_index_upd;

    assign rem_sh  = {rem_reg, quo_reg[VAL_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, item_reg.den};
    assign rem_sub = rem_sh - {1'b0, item_reg.den};

    assign quo_x      = {1'b0, quo_reg};
    assign quo_signed = item_reg.num_neg ? -quo_x : quo_x;
    assign delta_sat  = (quo_signed[VAL_W] != quo_signed[VAL_W-1])
                      ? (quo_signed[VAL_W] ? DELTA_MIN : DELTA_MAX)
                      : quo_signed[VAL_W-1:0];

    assign aspire_sum = $signed({cfg.current_mean[VAL_W-1], cfg.current_mean})
                      + $signed({delta_reg[VAL_W-1], delta_reg});
    assign admit = item_reg.usable && (!item_reg.tabu ||
                   aspire_sum > $signed({cfg.best_local_mean[VAL_W-1],
                                         cfg.best_local_mean}));
    assign take  = admit && (!leader_valid_reg ||
                   $signed(delta_reg) > $signed(leader_delta_reg));

    assign lead_valid_upd = leader_valid_reg || take;
    assign lead_delta_upd = take ? delta_reg : leader_delta_reg;
    assign lead_index_upd = take ? position_reg : leader_index_reg;

    assign out_free = !m_valid_reg || m_tready;
    assign done_go  = (state_reg == ST_DONE) && (!item_reg.last || out_free);
    assign emit     = done_go && item_reg.last;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;

    always_comb begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        quo_next          = quo_reg;
        rem_next          = rem_reg;
        position_next     = position_reg;
        leader_delta_next = leader_delta_reg;
        leader_index_next = leader_index_reg;
        leader_valid_next = leader_valid_reg;
        m_valid_next      = m_valid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    quo_next   = q_item.num_mag;
                    rem_next   = '0;
                    cnt_next   = DCNT_W'(DIV_STEPS - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                quo_next = {quo_reg[VAL_W-2:0], rem_ge};
                rem_next = rem_ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                cnt_next = cnt_reg - DCNT_W'(1);
                if (cnt_reg == '0) begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (done_go) begin
                    state_next    = ST_IDLE;
                    position_next = (position_reg == POS_W'(MAX_ELEMENTS - 1))
                                  ? '0 : position_reg + POS_W'(1);
                    leader_valid_next = lead_valid_upd;
                    leader_delta_next = lead_delta_upd;
                    leader_index_next = lead_index_upd;
                    if (item_reg.last) begin
                        m_valid_next      = 1'b1;
                        position_next     = '0;
                        leader_valid_next = 1'b0;
                        leader_delta_next = DELTA_MIN;
                        leader_index_next = '0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            position_reg     <= '0;
            leader_delta_reg <= DELTA_MIN;
            leader_index_reg <= '0;
            leader_valid_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            position_reg     <= position_next;
            leader_delta_reg <= leader_delta_next;
            leader_index_reg <= leader_index_next;
            leader_valid_reg <= leader_valid_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (q_pop) begin
            item_reg <= q_item;
        end
        if (state_reg == ST_FIX) begin
            delta_reg <= delta_sat;
        end
        if (emit) begin
            out_found_reg <= lead_valid_upd;
            out_index_reg <= lead_valid_upd ? IDX_W'(lead_index_upd) : '0;
            out_delta_reg <= lead_delta_upd;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = M_TDATA_W'({out_delta_reg, out_index_reg});

    // the partial remainder stays below the divisor while dividing a usable element
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && item_reg.usable) |-> (rem_reg < item_reg.den))
        else $error("divider remainder out of range");

    // a result appears only out of the decision step of a last element
    a_emit_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE && item_reg.last))
        else $error("result raised outside end of scan");

    // end of scan returns the scan state to its start
    a_scan_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> (!leader_valid_reg && position_reg == '0))
        else $error("scan state not cleared after result");

    // without a leader the stored delta is the floor value
    a_leader_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        !leader_valid_reg |-> (leader_delta_reg == DELTA_MIN))
        else $error("leader delta set without leader");

endmodule

`default_nettype wire

FILE: rtl/tabu_best_flip_scan_unit.sv
`default_nettype none

// best-move scan of a tabu search: one element per input transfer, in scan
// order; each element gets its mean gain delta = (p - f) / (m + 1) when outside
// the set or (f - p) / (m - 1) when inside (never admitted for m <= 2), in
// signed Q16.16, truncated toward zero and saturated to 32 bits; a tabu element
// (expiry > iteration) counts only when f + delta beats the best local mean;
// the first strict maximum is kept and the transfer with tlast set produces one
// result transfer (found flag, scan index, delta) and restarts the scan.
// a front classifier forms numerator, divisor and tabu flag at the input and
// pushes into a two-entry queue, so the input side takes items while the back
// end is busy; the back end takes one element at a time through a load, 32
// steps of the shared bit-serial divider, a sign/saturation step and a
// selection step before the next; that step of a last element waits while
// an earlier result transfer is still pending. configuration registers are
// written through cfg_wr_en / cfg_index / cfg_wdata; the user must write them
// only while the unit is idle, which the block itself does not enforce

module tabu_best_flip_scan_unit (
    input  wire                             aclk,
    input  wire                             aresetn,

    // configuration writes
    input  wire                             cfg_wr_en,
    input  wire [tbfs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire [tbfs_pkg::CFG_W-1:0]       cfg_wdata,

    // element stream
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire [tbfs_pkg::S_TDATA_W-1:0]   s_tdata,   // gain_value[31:0], tabu_expiry[79:32]
    input  wire                             s_tuser,   // in_set
    input  wire                             s_tlast,   // last element of the scan

    // result stream
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [tbfs_pkg::M_TDATA_W-1:0]  m_tdata,   // best_index[11:0], move_delta[43:12], zeros
    output logic                            m_tuser    // found
);
    import tbfs_pkg::*;

    tbfs_cfg_t   cfg_reg;
    tbfs_item_t  front_item;
    tbfs_item_t  queue_item;
    logic        front_push;
    logic        queue_full;
    logic        queue_valid;
    logic        queue_pop;

    // configuration registers, all clear to zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CURRENT_MEAN:    cfg_reg.current_mean    <= cfg_wdata[VAL_W-1:0];
                REG_BEST_LOCAL_MEAN: cfg_reg.best_local_mean <= cfg_wdata[VAL_W-1:0];
                REG_ITERATION:       cfg_reg.iteration       <= cfg_wdata[ITER_W-1:0];
                REG_SET_SIZE:        cfg_reg.set_size        <= cfg_wdata[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // classify at the input side
    tbfs_front u_front (
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (queue_full),
        .q_push   (front_push),
        .q_item   (front_item)
    );

    // decouples input transfers from the divider
    tbfs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (front_push),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_item  (queue_item),
        .valid     (queue_valid)
    );

    // divide, saturate, select the leader, emit at end of scan
    tbfs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (queue_valid),
        .q_item   (queue_item),
        .q_pop    (queue_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

FILE: tb/tbfs_scan_checker.sv
`default_nettype none

module tbfs_scan_checker (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               cfg_wr_en,
    input  wire [tbfs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [tbfs_pkg::CFG_W-1:0]         cfg_wdata,
    input  wire                               s_tvalid,
    input  wire                               s_tready,
    input  wire [tbfs_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire                               s_tuser,
    input  wire                               s_tlast,
    input  wire                               m_tvalid,
    input  wire                               m_tready,
    input  wire [tbfs_pkg::M_TDATA_W-1:0]     m_tdata,
    input  wire                               m_tuser,
    output int                                mismatches,
    output int                                pending
);

    timeunit 1ns;
    timeprecision 1ps;

    import tbfs_pkg::*;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] index;
        logic [VAL_W-1:0] delta;
    } best_move_t;

    // shadow of the configuration registers
    logic signed [VAL_W-1:0] cur_mean;
    logic signed [VAL_W-1:0] best_local;
    logic [ITER_W-1:0]       cur_iter;
    logic [SIZE_W-1:0]       set_size;

    // scan state
    logic [POS_W-1:0] scan_pos;
    longint           lead_gain;
    logic [IDX_W-1:0] lead_pos;
    bit               lead_valid;

    best_move_t       best_move_q[$];
    best_move_t       want;
    logic [IDX_W-1:0] got_index;
    logic [VAL_W-1:0] got_delta;
    longint           gain;
    bit               admitted;

    // mean gain of flipping one element; returns whether the flip may be taken
    function automatic bit flip_gain(input logic signed [VAL_W-1:0] p, input logic member,
                                     input logic [ITER_W-1:0] expiry, output longint q);
        longint num;
        longint den;
        q = 0;
        if (!member) begin
            num = longint'(p) - longint'(cur_mean);
            den = longint'(set_size) + 1;
        end else if (set_size <= 2) begin
            return 1'b0;
        end else begin
            num = longint'(cur_mean) - longint'(p);
            den = longint'(set_size) - 1;
        end
        q = num / den;
        if (q > 64'sd2147483647)
            q = 64'sd2147483647;
        else if (q < -64'sd2147483648)
            q = -64'sd2147483648;
        // tabu moves pass only through aspiration
        if (expiry > cur_iter && longint'(cur_mean) + q <= longint'(best_local))
            return 1'b0;
        return 1'b1;
    endfunction

    task automatic note_failure(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t checker: %s", $time, what);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cur_mean   = '0;
            best_local = '0;
            cur_iter   = '0;
            set_size   = '0;
            scan_pos   = '0;
            lead_gain  = -64'sd2147483648;
            lead_pos   = '0;
            lead_valid = 1'b0;
            best_move_q.delete();
            mismatches = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_index = m_tdata[IDX_W-1:0];
                got_delta = m_tdata[IDX_W +: VAL_W];
                if (best_move_q.size() == 0) begin
                    note_failure($sformatf({"result transfer with none expected: ",
                                            "found=%0b index=%0d delta=%h"},
                                           m_tuser, got_index, got_delta));
                end else begin
                    want = best_move_q.pop_front();
                    if (m_tuser !== want.found || got_index !== want.index ||
                        got_delta !== want.delta || m_tdata[M_TDATA_W-1:IDX_W+VAL_W] !== '0)
                        note_failure($sformatf({"result mismatch: expected found=%0b index=%0d ",
                                                "delta=%h, got found=%0b index=%0d delta=%h pad=%h"},
                                               want.found, want.index, want.delta, m_tuser,
                                               got_index, got_delta,
                                               m_tdata[M_TDATA_W-1:IDX_W+VAL_W]));
                end
            end

            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_CURRENT_MEAN:    cur_mean   = cfg_wdata[VAL_W-1:0];
                    REG_BEST_LOCAL_MEAN: best_local = cfg_wdata[VAL_W-1:0];
                    REG_ITERATION:       cur_iter   = cfg_wdata[ITER_W-1:0];
                    REG_SET_SIZE:        set_size   = cfg_wdata[SIZE_W-1:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                admitted = flip_gain(s_tdata[VAL_W-1:0], s_tuser, s_tdata[VAL_W +: ITER_W], gain);
                // first admitted element always leads, later ones need a strictly larger gain
                if (admitted && (!lead_valid || gain > lead_gain)) begin
                    lead_gain  = gain;
                    lead_pos   = IDX_W'(scan_pos);
                    lead_valid = 1'b1;
                end
                if (scan_pos == POS_W'(MAX_ELEMENTS - 1))
                    scan_pos = '0;
                else
                    scan_pos = scan_pos + 1'b1;
                if (s_tlast) begin
                    want.found = lead_valid;
                    want.index = lead_valid ? lead_pos : '0;
                    want.delta = lead_valid ? VAL_W'(lead_gain) : DELTA_MIN;
                    best_move_q = {best_move_q, want};
                    scan_pos   = '0;
                    lead_gain  = -64'sd2147483648;
                    lead_pos   = '0;
                    lead_valid = 1'b0;
                end
            end
        end
        pending = best_move_q.size();
    end

endmodule

`default_nettype wire

FILE: tb/tb_tabu_best_flip_scan_unit.sv
`default_nettype none

module tb_tabu_best_flip_scan_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import tbfs_pkg::*;

    // length of the longer directed scan
    localparam int LONG_SCAN = 64;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_CURRENT_MEAN;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // gain_value[31:0], tabu_expiry[79:32]
    logic                 s_tuser   = 1'b0; // in_set
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // best_index[11:0], move_delta[43:12], zeros
    logic                 m_tuser;          // found

    int fail_count;
    int pending;

    // sender-side copies of the registers, used to aim the random fields
    logic [VAL_W-1:0]  mean_now = '0;
    logic [ITER_W-1:0] iter_now = '0;

    // remaining items of a stretch with no idling, per side
    int send_calm = 0;
    int recv_calm = 0;
    int rand_items;
    int scans_left;
    int scan_len;

    always #6 aclk = ~aclk;

    tabu_best_flip_scan_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    tbfs_scan_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (fail_count),
        .pending    (pending)
    );

    // idle cycles before the next transfer, drawn at random, with occasional runs of zero
    function automatic int idle_cycles(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm_left = $urandom_range(8, 30);
        return $urandom_range(0, 11);
    endfunction

    // p values: extremes, values near f, small Q16.16 numbers, anything
    function automatic logic [VAL_W-1:0] pick_gain();
        case ($urandom_range(0, 9))
            0:       return DELTA_MIN;
            1:       return DELTA_MAX;
            2:       return mean_now + VAL_W'($urandom_range(0, 64)) - VAL_W'(32);
            3:       return VAL_W'($urandom_range(0, 32'h0003_ffff));
            4:       return -VAL_W'($urandom_range(0, 32'h0003_ffff));
            default: return $urandom;
        endcase
    endfunction

    // expiry values clustered around the tabu boundary
    function automatic logic [ITER_W-1:0] pick_expiry();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return iter_now;
            3:       return iter_now + 1'b1;
            4:       return iter_now - 1'b1;
            default: return ITER_W'({$urandom, $urandom});
        endcase
    endfunction

    // one element transfer, after a random idle stretch
    task automatic send_element(input logic [VAL_W-1:0] p, input logic member,
                                input logic [ITER_W-1:0] expiry, input logic tail);
        int gap;
        gap = idle_cycles(send_calm);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {expiry, p};
        s_tuser  <= member;
        s_tlast  <= tail;
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold off until every result is in, then let the back end go quiet
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (120) @(negedge aclk);
    endtask

    // write all four registers on consecutive cycles, unit idle
    task automatic program_scan(input logic [VAL_W-1:0] f, input logic [VAL_W-1:0] blm,
                                input logic [ITER_W-1:0] iter, input logic [SIZE_W-1:0] m);
        drain_results();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_CURRENT_MEAN;
        cfg_wdata <= CFG_W'(f);
        @(negedge aclk);
        cfg_index <= REG_BEST_LOCAL_MEAN;
        cfg_wdata <= CFG_W'(blm);
        @(negedge aclk);
        cfg_index <= REG_ITERATION;
        cfg_wdata <= CFG_W'(iter);
        @(negedge aclk);
        cfg_index <= REG_SET_SIZE;
        cfg_wdata <= CFG_W'(m);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        mean_now = f;
        iter_now = iter;
    endtask

    // random register setting, extremes included
    task automatic program_random();
        logic [VAL_W-1:0]  f;
        logic [VAL_W-1:0]  blm;
        logic [ITER_W-1:0] iter;
        logic [SIZE_W-1:0] m;
        case ($urandom_range(0, 5))
            0:       f = DELTA_MIN;
            1:       f = DELTA_MAX;
            2:       f = '0;
            default: f = $urandom;
        endcase
        case ($urandom_range(0, 6))
            0:       blm = DELTA_MIN;
            1:       blm = DELTA_MAX;
            2:       blm = f;
            3:       blm = f + VAL_W'($urandom_range(0, 32'h0002_0000));
            default: blm = $urandom;
        endcase
        case ($urandom_range(0, 4))
            0:       iter = '0;
            1:       iter = '1;
            default: iter = ITER_W'({$urandom, $urandom});
        endcase
        case ($urandom_range(0, 5))
            0:       m = SIZE_W'($urandom_range(0, 3));
            1:       m = SIZE_W'($urandom_range(0, 8191));
            2:       m = ($urandom_range(0, 1) != 0) ? SIZE_W'(4096) : SIZE_W'(8191);
            default: m = SIZE_W'($urandom_range(3, 24));
        endcase
        program_scan(f, blm, iter, m);
    endtask

    // result side: random stalls before each transfer
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            stall = idle_cycles(recv_calm);
            @(negedge aclk);
            m_tready <= (stall == 0);
            if (stall > 0) begin
                repeat (stall - 1) @(negedge aclk);
                @(negedge aclk);
                m_tready <= 1'b1;
            end
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // overall limit
    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty set: divisor is one, so each quotient is p - f; removal never taken
        program_scan('0, '0, '0, SIZE_W'(0));
        send_element(DELTA_MAX, 1'b0, '0, 1'b0);
        send_element(DELTA_MIN, 1'b0, '0, 1'b0);
        send_element(32'd5, 1'b1, '0, 1'b1);
        // nothing admitted
        send_element(32'd5, 1'b1, '1, 1'b1);
        // tabu with aspiration: gain 1 passes, gain 0 does not
        send_element(32'd1, 1'b0, 48'd1, 1'b0);
        send_element(32'd0, 1'b0, 48'd1, 1'b1);

        // saturated ties: first most-negative gain leads
        program_scan(DELTA_MAX, DELTA_MIN, '1, SIZE_W'(0));
        send_element(DELTA_MIN, 1'b0, '0, 1'b0);
        send_element(32'h8000_0001, 1'b0, '1, 1'b0);
        send_element(DELTA_MIN, 1'b1, '1, 1'b1);

        // removal with m = 3, expiry equal to the iteration is not tabu
        program_scan(DELTA_MIN, DELTA_MAX, 48'd100, SIZE_W'(3));
        send_element(DELTA_MAX, 1'b1, '0, 1'b0);
        send_element(DELTA_MIN, 1'b0, 48'd101, 1'b0);
        send_element(DELTA_MAX, 1'b0, 48'd100, 1'b0);
        send_element(32'hffff_0000, 1'b1, 48'd99, 1'b1);

        // largest 13-bit set size, every element tabu and failing aspiration
        program_scan(32'h0001_0000, DELTA_MAX, 48'hffff_ffff_fffe, SIZE_W'(8191));
        send_element(32'h1234_5678, 1'b0, '1, 1'b0);
        send_element(32'hffff_ffff, 1'b1, '1, 1'b1);

        // two-element set: removal skipped, adds compete
        program_scan('0, '0, '0, SIZE_W'(2));
        send_element(32'd100, 1'b1, '0, 1'b0);
        send_element(-32'sd300, 1'b0, '0, 1'b0);
        send_element(32'd300, 1'b0, '0, 1'b1);

        // longer scan: the leader sits near its end
        for (int i = 0; i < LONG_SCAN; i++) begin
            if (i == 5)
                send_element(32'd300, 1'b0, pick_expiry(), 1'b0);
            else if (i == LONG_SCAN - 2)
                send_element(32'd3000, 1'b0, '0, 1'b0);
            else
                send_element($urandom, 1'b1, pick_expiry(), i == LONG_SCAN - 1);
        end

        // random scans, fresh registers every few scans
        rand_items = 0;
        scans_left = 0;
        while (rand_items < 1260) begin
            if (scans_left == 0) begin
                program_random();
                scans_left = $urandom_range(1, 4);
            end
            scans_left--;
            scan_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(1, 12);
            for (int i = 0; i < scan_len; i++)
                send_element(pick_gain(), 1'($urandom_range(0, 1)), pick_expiry(),
                             i == scan_len - 1);
            rand_items += scan_len;
        end

        drain_results();
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

FILE: tabu_best_flip_scan_unit.f
rtl/tbfs_pkg.sv
rtl/tbfs_front.sv
rtl/tbfs_queue.sv
rtl/tbfs_back.sv
rtl/tabu_best_flip_scan_unit.sv
tb/tbfs_scan_checker.sv
tb/tb_tabu_best_flip_scan_unit.sv
